>>> rtl/sxf_pkg.sv
`default_nettype none

package sxf_pkg;

	// Item kinds carried on the input tuser.
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// One sprite row is eight pixels, most significant bit leftmost.
	localparam int SPRITE_BITS = 8;

	// Widths of the packed stream words.
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // latch an accepted beat and start the coordinate wrap
		logic calc;    // finish the wrap and issue the row read
		logic commit;  // modify and write the row on a draw, load the result register
	} sxf_cmd_t;

endpackage

`default_nettype wire

>>> rtl/sxf_ram.sv
`default_nettype none

module sxf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/sxf_ctrl.sv
`default_nettype none

module sxf_ctrl
	import sxf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output sxf_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_MOD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free   = !out_valid_q || m_tready;
	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = out_valid_q;
	assign cmd.load   = s_tvalid && s_tready;
	assign cmd.calc   = (state_q == ST_CALC);
	assign cmd.commit = (state_q == ST_MOD) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_MOD;
			end
			ST_MOD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An accepted beat always moves on to the wrap step.
	a_load_then_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.calc)
		else $error("accepted beat did not enter the wrap step");

	// A committed item always shows up on the output next cycle.
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("committed result not presented");

	// The three datapath commands never overlap.
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.calc, cmd.commit}))
		else $error("overlapping datapath commands");

endmodule

`default_nettype wire

>>> rtl/sxf_datapath.sv
`default_nettype none

module sxf_datapath
	import sxf_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire sxf_cmd_t               cmd,
	input  wire logic [1:0]             op,
	input  wire logic [7:0]             x_coord,
	input  wire logic [7:0]             y_coord,
	input  wire logic [3:0]             row_index,
	input  wire logic [SPRITE_BITS-1:0] sprite_byte,
	input  wire logic                   last_row,
	output logic                        collision,
	output logic                        pixel_value
);

	localparam int X_W    = $clog2(SCREEN_WIDTH);
	localparam int Y_W    = $clog2(SCREEN_HEIGHT);
	localparam int V_W    = 9;
	localparam int SHIFT  = 18;
	localparam int PROD_W = V_W + SHIFT;
	localparam int QW_W   = V_W + 8;
	localparam int RECIP_X = (1 << SHIFT) / SCREEN_WIDTH;
	localparam int RECIP_Y = (1 << SHIFT) / SCREEN_HEIGHT;

	// Stage one: raw coordinates and reciprocal quotient estimates.
	logic [1:0]             op_q;
	logic [SPRITE_BITS-1:0] bits_q;
	logic                   last_q;
	logic [V_W-1:0]         vx_s1;
	logic [V_W-1:0]         vy_s1;
	logic [V_W-1:0]         qx_s1;
	logic [V_W-1:0]         qy_s1;

	logic [V_W-1:0]    vx_in;
	logic [V_W-1:0]    vy_in;
	logic [PROD_W-1:0] prod_x;
	logic [PROD_W-1:0] prod_y;

	// Stage two: wrapped coordinates.
	logic [X_W-1:0]  ax_s2;
	logic [Y_W-1:0]  ay_s2;
	logic [QW_W-1:0] rem_x;
	logic [QW_W-1:0] rem_y;
	logic [X_W:0]    rx;
	logic [Y_W:0]    ry;
	logic [X_W-1:0]  ax_d;
	logic [Y_W-1:0]  ay_d;

	// Row update.
	logic [SCREEN_WIDTH-1:0]  ram_rd;
	logic [SCREEN_WIDTH-1:0]  row_cur;
	logic [SCREEN_WIDTH-1:0]  mask;
	logic [SCREEN_WIDTH-1:0]  row_new;
	logic                     hit;
	logic [SCREEN_HEIGHT-1:0] valid_q;
	logic                     accum_q;
	logic                     wr_en;
	logic                     coll_q;
	logic                     pix_q;

	assign vx_in  = {1'b0, x_coord};
	assign vy_in  = (op == OP_DRAW) ? ({1'b0, y_coord} + V_W'(row_index)) : {1'b0, y_coord};
	assign prod_x = PROD_W'(vx_in) * PROD_W'(RECIP_X);
	assign prod_y = PROD_W'(vy_in) * PROD_W'(RECIP_Y);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			bits_q <= sprite_byte;
			last_q <= last_row;
			vx_s1  <= vx_in;
			vy_s1  <= vy_in;
			qx_s1  <= prod_x[PROD_W-1:SHIFT];
			qy_s1  <= prod_y[PROD_W-1:SHIFT];
		end
	end

	// The quotient estimate is low by at most one, so one correction suffices.
	assign rem_x = QW_W'(vx_s1) - (QW_W'(qx_s1) * QW_W'(SCREEN_WIDTH));
	assign rem_y = QW_W'(vy_s1) - (QW_W'(qy_s1) * QW_W'(SCREEN_HEIGHT));

	always_comb begin
		rx = rem_x[X_W:0];
		if (rx >= (X_W+1)'(SCREEN_WIDTH)) begin
			rx = rx - (X_W+1)'(SCREEN_WIDTH);
		end
		ry = rem_y[Y_W:0];
		if (ry >= (Y_W+1)'(SCREEN_HEIGHT)) begin
			ry = ry - (Y_W+1)'(SCREEN_HEIGHT);
		end
		ax_d = rx[X_W-1:0];
		ay_d = ry[Y_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			ax_s2 <= ax_d;
			ay_s2 <= ay_d;
		end
	end

	assign wr_en = cmd.commit && (op_q == OP_DRAW);

	sxf_ram #(
		.WIDTH(SCREEN_WIDTH),
		.DEPTH(SCREEN_HEIGHT)
	) u_rows (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(ay_s2),
		.wr_data(row_new),
		.rd_en  (cmd.calc),
		.rd_addr(ay_d),
		.rd_data(ram_rd)
	);

	// A row never written since the last clear reads as blank.
	assign row_cur = valid_q[ay_s2] ? ram_rd : '0;

	always_comb begin
		logic [X_W:0] col;
		mask = '0;
		for (int k = 0; k < SPRITE_BITS; k++) begin
			col = {1'b0, ax_s2} + (X_W+1)'(k);
			if (col >= (X_W+1)'(SCREEN_WIDTH)) begin
				col = col - (X_W+1)'(SCREEN_WIDTH);
			end
			if (bits_q[SPRITE_BITS-1-k]) begin
				mask[col[X_W-1:0]] = 1'b1;
			end
		end
	end

	assign row_new = row_cur ^ mask;
	assign hit     = |(row_cur & mask);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			accum_q <= 1'b0;
		end else if (cmd.commit) begin
			case (op_q)
				OP_CLEAR: begin
					valid_q <= '0;
				end
				OP_DRAW: begin
					valid_q[ay_s2] <= 1'b1;
					accum_q        <= last_q ? 1'b0 : (accum_q | hit);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			coll_q <= (op_q == OP_DRAW) && last_q && (accum_q || hit);
			pix_q  <= (op_q == OP_READ) && row_cur[ax_s2];
		end
	end

	assign collision   = coll_q;
	assign pixel_value = pix_q;

endmodule

`default_nettype wire

>>> rtl/sprite_xor_framebuffer_top.sv
`default_nettype none

// Monochrome XOR sprite frame buffer of SCREEN_WIDTH x SCREEN_HEIGHT pixels.
// Each input beat is one item: clear the screen, draw one 8-pixel sprite row
// at (x, y + row_index), or read one pixel at (x, y); coordinates wrap modulo
// the screen size. A set sprite bit toggles its pixel, and turning a lit pixel
// off counts as a collision. Collisions gather over the rows of one sprite and
// are reported on the draw beat that carries tlast, which also clears them.
// Every input beat produces exactly one output beat; collision and pixel value
// read zero wherever they do not apply. An item passes three steps: the load
// step latches the beat and forms the reciprocal quotients of the coordinates,
// the calc step finishes the wrap and reads the buffer row from the row RAM,
// and the commit step modifies and, for a draw, writes that row back and loads
// the result register. Only one item is in flight at a time, so the input is
// ready again only after the commit step and takes no new beat while an item
// is in progress; this is set by the controller running the three steps of the
// row read-modify-write in sequence. A finished result waits in its own output
// register, so the next beat is accepted while it is still pending; the row
// write of that next item waits only if the earlier result has not yet been
// taken. Clear costs no extra time: a per-row valid bit marks rows written
// since the last clear, and clearing drops all of them at once, so no sweep of
// the buffer follows reset or a clear.
module sprite_xor_framebuffer_top
	import sxf_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// s_tdata: x_coord[7:0], y_coord[15:8], row_index[19:16],
	// sprite_byte[27:20], zero fill[31:28]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: op[1:0] (clear, draw row, read pixel)
	input  wire logic [1:0]            s_tuser,
	// s_tlast: last row of the sprite
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// m_tdata: collision[0], pixel_value[1], zero fill[7:2]
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	sxf_cmd_t cmd;
	logic     collision;
	logic     pixel_value;

	// Sequencing of the three steps and the output handshake.
	sxf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd)
	);

	// Coordinate wrap, row RAM, XOR update and collision accumulation.
	sxf_datapath #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.op         (s_tuser),
		.x_coord    (s_tdata[7:0]),
		.y_coord    (s_tdata[15:8]),
		.row_index  (s_tdata[19:16]),
		.sprite_byte(s_tdata[27:20]),
		.last_row   (s_tlast),
		.collision  (collision),
		.pixel_value(pixel_value)
	);

	assign m_tdata = {(OUT_DATA_W-2)'(0), pixel_value, collision};

endmodule

`default_nettype wire
